>>> rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

	// byte source for the block shift line
	localparam logic [1:0] SEL_DATA = 2'd0;
	localparam logic [1:0] SEL_PAD  = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	// round groups
	localparam logic [1:0] GRP_CH  = 2'd0;
	localparam logic [1:0] GRP_P1  = 2'd1;
	localparam logic [1:0] GRP_MAJ = 2'd2;
	localparam logic [1:0] GRP_P3  = 2'd3;

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_IDX   = 3'd4;
	localparam logic [5:0] LAST_FILL  = 6'd63;

	typedef struct packed {
		logic       shift;   // shift one byte into the block
		logic [1:0] sel;     // byte source
		logic       count;   // add 8 to the bit count
		logic       round;   // run one compression round
		logic [1:0] grp;     // round group
		logic       add;     // fold working words into chain
		logic       init;    // start a new message
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte intake, padding, round count and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        byte_valid,
	input  wire logic        end_of_message,
	input  wire logic        out_ready,
	input  wire logic [5:0]  fill,
	output logic             in_ready,
	output logic             out_valid,
	output logic [2:0]       out_idx,
	output sha1_pkg::cmd_t   cmd
);
	import sha1_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [6:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q;
	logic       first_q;
	logic       wrap_q;
	logic       in_acc;
	logic       out_acc;
	logic       tail;
	logic       full;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_idx   = idx_q;
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign tail      = (fill[5:3] == 3'b111);
	assign full      = (fill == LAST_FILL);

	always_comb begin
		cmd = '0;
		cmd.sel = SEL_ZERO;
		if (rnd_q < 7'd20) begin
			cmd.grp = GRP_CH;
		end else if (rnd_q < 7'd40) begin
			cmd.grp = GRP_P1;
		end else if (rnd_q < 7'd60) begin
			cmd.grp = GRP_MAJ;
		end else begin
			cmd.grp = GRP_P3;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && byte_valid) begin
					cmd.shift = 1'b1;
					cmd.sel   = SEL_DATA;
					cmd.count = 1'b1;
				end
			end
			ST_PAD: begin
				cmd.shift = 1'b1;
				if (first_q) begin
					cmd.sel = SEL_PAD;
				end else if (tail && !wrap_q) begin
					cmd.sel = SEL_LEN;
				end else begin
					cmd.sel = SEL_ZERO;
				end
			end
			ST_COMP: cmd.round = 1'b1;
			ST_ADD:  cmd.add = 1'b1;
			ST_OUT: begin
				if (out_acc && idx_q == LAST_IDX) begin
					cmd.init = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			wrap_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (end_of_message) begin
							fin_q   <= 1'b1;
							first_q <= 1'b1;
						end
						if (byte_valid && full) begin
							state_q <= ST_COMP;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (first_q) begin
						first_q <= 1'b0;
						wrap_q  <= tail;
					end
					if (full) begin
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND) begin
						rnd_q   <= '0;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (first_q || wrap_q) begin
						wrap_q  <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						fin_q   <= 1'b0;
						idx_q   <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/sha1_dp.sv
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: block shift line / message schedule, round unit, chain words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_dp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sha1_pkg::cmd_t cmd,
	input  wire logic [7:0]  data_byte,
	input  wire logic [2:0]  out_idx,
	output logic [5:0]       fill,
	output logic [31:0]      digest_word
);
	import sha1_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] chain_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] bits_q;
	logic [5:0]  fill_q;
	logic [7:0]  byte_in;
	logic [2:0]  lsel;
	logic [31:0] f, k, t, w_new, w_mix;

	assign fill = fill_q;
	assign lsel = 3'd7 - fill_q[2:0];
	assign digest_word = (out_idx <= LAST_IDX) ? chain_q[out_idx] : '0;

	always_comb begin
		unique case (cmd.sel)
			SEL_DATA: byte_in = data_byte;
			SEL_PAD:  byte_in = 8'h80;
			SEL_LEN:  byte_in = bits_q[{lsel, 3'b000} +: 8];
			default:  byte_in = 8'h00;
		endcase
	end

	always_comb begin
		unique case (cmd.grp)
			GRP_CH: begin
				f = (b_q & c_q) | (~b_q & d_q);
				k = K_R0;
			end
			GRP_P1: begin
				f = b_q ^ c_q ^ d_q;
				k = K_R1;
			end
			GRP_MAJ: begin
				f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k = K_R2;
			end
			default: begin
				f = b_q ^ c_q ^ d_q;
				k = K_R3;
			end
		endcase
	end

	assign t     = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
	assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {w_mix[30:0], w_mix[31]};

	// shift line: bytes in at the bottom, word 0 is the next schedule word
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], byte_in};
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift && fill_q == LAST_FILL) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= H_INIT[i];
			end
			bits_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.init) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= H_INIT[i];
				end
			end else if (cmd.add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.init) begin
				bits_q <= '0;
			end else if (cmd.count) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.init) begin
				fill_q <= '0;
			end else if (cmd.shift) begin
				fill_q <= fill_q + 6'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/sha1_digest.sv
// ----------------------------------------------------------------------------
// sha1_digest
// Streaming SHA-1 hash: one message byte per input beat, five digest beats.
// ----------------------------------------------------------------------------
// Feed the message one byte per input beat (byte_valid marks a real byte,
// end_of_message closes the message after that beat's byte; a beat with only
// the mark closes it as it stands, so an empty message works). The beat that
// completes a 64-byte block is followed by a busy stretch: 80 rounds of the
// single round unit, then a fold of the working words into the chain. After
// the end mark, padding shifts in one byte per cycle (0x80, zeros, then the
// 64-bit big-endian bit length) and runs one or two more compressions. The
// digest then leaves as five output beats, word 0 (most significant) first,
// last_word on word 4; input is held off until the last one is taken, and
// the block is then ready for the next message. The bit count wraps modulo
// 2^64. No input is taken while a block is padded or compressed or a digest
// is being delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_digest (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	import sha1_pkg::*;

	cmd_t       cmd;
	logic [5:0] fill;
	logic [2:0] out_idx;

	// sequencer: owns the state, round count and output word count
	sha1_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.out_ready      (out_ready),
		.fill           (fill),
		.in_ready       (in_ready),
		.out_valid      (out_valid),
		.out_idx        (out_idx),
		.cmd            (cmd)
	);

	// datapath: block shift line doubles as the 16-word schedule window
	sha1_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.out_idx     (out_idx),
		.fill        (fill),
		.digest_word (digest_word)
	);

	// word index and the last mark come straight from the output counter
	assign word_index = out_idx;
	assign last_word  = (out_idx == LAST_IDX);

endmodule

`default_nettype wire

>>> rtl/sha1_checker.sv
// ----------------------------------------------------------------------------
// sha1_checker
// Port-level checks for the SHA-1 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_index,
	input wire logic        last_word
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word)
			&& $stable(word_index))
		else $error("stalled digest beat changed");

	// no input taken while a digest is being delivered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during digest output");

	// last mark only on word four
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd4)))
		else $error("last_word mismatch");

	// advance the word index beat by beat
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid
			&& word_index == $past(word_index) + 3'd1)
		else $error("digest words out of sequence");

	// first word of a digest is word zero
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> word_index == 3'd0)
		else $error("digest did not start at word zero");

endmodule

bind sha1_digest sha1_checker u_sha1_checker (.*);

`default_nettype wire
